>>> src/izk_pkg.sv
// Package for the Izhikevich neuron update unit: Q16.16 constants,
// controller command/status types and the saturating helpers. No dependencies.
package izk_pkg;
    localparam int unsigned NEURON_COUNT_DEF = 256;
    localparam int unsigned IDX_W = 8;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] K_THRESH = 32'sd1966080;
    localparam logic signed [31:0] K_QUAD = 32'sd2621;
    localparam logic signed [31:0] K_LIN = 32'sd327680;
    localparam logic signed [31:0] K_CONST = 32'sd9175040;
    localparam logic signed [31:0] K_HALF = 32'sd32768;
    localparam logic signed [31:0] V_INIT = -32'sd4259840;
    localparam logic signed [31:0] U_INIT = -32'sd1310720;
    localparam logic [30:0] DT_RESET = 31'd6554;
    localparam logic signed [31:0] IOFF_RESET = 32'sd655360;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;
    localparam logic REG_TIME_STEP = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    // Datapath micro-operations issued by the controller.
    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_READ = 4'd1;
    localparam logic [3:0] OP_FETCH = 4'd2;
    localparam logic [3:0] OP_SPIKE = 4'd3;
    localparam logic [3:0] OP_M_QV = 4'd4;
    localparam logic [3:0] OP_M_QVV = 4'd5;
    localparam logic [3:0] OP_M_LV = 4'd6;
    localparam logic [3:0] OP_SUM = 4'd7;
    localparam logic [3:0] OP_M_HS = 4'd8;
    localparam logic [3:0] OP_M_DT = 4'd9;
    localparam logic [3:0] OP_M_BV = 4'd10;
    localparam logic [3:0] OP_M_AB = 4'd11;
    localparam logic [3:0] OP_M_DTU = 4'd12;
    localparam logic [3:0] OP_WRITE = 4'd13;
    localparam logic [3:0] OP_LOAD = 4'd14;
    localparam logic [3:0] OP_V_ACC = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic over;
        logic in_range;
    } t_stat;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
        if (x > 33'sd2147483647) begin
            return Q_MAX;
        end else if (x < -33'sd2147483648) begin
            return Q_MIN;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
        return sat33(33'(x) + 33'(y));
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
        return sat33(33'(x) - 33'(y));
    endfunction

    // Round the 64-bit product to Q16.16 (ties up) and saturate.
    function automatic logic signed [31:0] qround(input logic signed [63:0] p);
        logic signed [64:0] t;
        logic signed [48:0] r;
        t = 65'(p) + 65'sd32768;
        r = t[64:16];
        if (r > 49'sd2147483647) begin
            return Q_MAX;
        end else if (r < -49'sd2147483648) begin
            return Q_MIN;
        end
        return r[31:0];
    endfunction
endpackage

>>> src/izhikevich_neuron_update_unit.sv
// Izhikevich neuron update unit: accepts load/step items, updates per-neuron
// V and U in Q16.16 with one shared multiplier. Uses izk_pkg, izk_ctrl, izk_datapath.
//
// Usage:
//   Input channel i_valid/o_stall carries one command item; output channel
//   o_valid/i_stall carries exactly one result item per input item.
//   A step goes through read, fetch, spike test, two half steps of seven
//   operations, recovery update, write back and output; a load or an
//   out-of-range index goes from fetch straight to output. The pace is set
//   by the single 32x32 multiplier and its product register.
//   One item is in work at a time; the next is accepted once the result has
//   moved into the output register, so a waiting result does not hold the
//   input side while the output register is free.
//   Reset clears the controller, restores the two registers to dt = 0.1 and
//   Ioffset = 10.0 and marks every neuron state as its reset value (V -65,
//   U -20) through per-neuron valid bits; no clearing pass is needed.
//   While i_stall is high the result holds in the output register and the
//   unit finishes at most one further item, then waits. The user, not the unit,
//   must write registers through i_cfg_we/i_cfg_addr/i_cfg_data only while idle.
module izhikevich_neuron_update_unit import izk_pkg::*; #(
    parameter int unsigned NEURON_COUNT = NEURON_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic [IDX_W-1:0]   i_neuron,
    input  logic signed [31:0] i_syn_current,
    input  logic signed [31:0] i_param_a,
    input  logic signed [31:0] i_param_b,
    input  logic signed [31:0] i_param_c,
    input  logic signed [31:0] i_param_d,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [IDX_W-1:0]   o_neuron_out,
    output logic signed [31:0] o_voltage,
    output logic signed [31:0] o_recovery,
    output logic               o_spiked
);
    logic [30:0]        r_dt;
    logic signed [31:0] r_ioff;
    logic               r_ovalid;
    logic               w_out_set, w_out_free, w_take;
    t_cmd               w_cmd;
    t_stat              w_stat;
    logic [IDX_W-1:0]   w_idx;
    logic signed [31:0] w_v, w_u;
    logic               w_spk;

    assign w_take = i_valid && !o_stall;
    assign w_out_free = !r_ovalid || !i_stall;
    assign o_valid = r_ovalid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= DT_RESET;
            r_ioff <= IOFF_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_TIME_STEP) begin
                r_dt <= i_cfg_data[30:0];
            end else if (i_cfg_addr == REG_OFFSET) begin
                r_ioff <= $signed(i_cfg_data);
            end
        end
    end

    izk_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_cmd(i_command),
        .i_out_free(w_out_free), .i_stat(w_stat), .o_stall(o_stall),
        .o_out_set(w_out_set), .o_cmd(w_cmd)
    );

    izk_datapath #(.NEURON_COUNT(NEURON_COUNT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(w_take), .i_neuron(i_neuron),
        .i_syn(i_syn_current), .i_pa(i_param_a), .i_pb(i_param_b),
        .i_pc(i_param_c), .i_pd(i_param_d), .i_dt(r_dt), .i_ioff(r_ioff),
        .i_cmd(w_cmd), .o_stat(w_stat), .o_idx(w_idx), .o_v(w_v), .o_u(w_u),
        .o_spk(w_spk)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_set) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_set) begin
            o_neuron_out <= w_idx;
            o_voltage <= w_v;
            o_recovery <= w_u;
            o_spiked <= w_spk;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |-> !w_out_set)
        else $error("result overwritten while stalled");
    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_set |-> o_stall)
        else $error("result produced while idle");
    a_load_no_spike: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_set && w_cmd.out_load) |=> !o_spiked)
        else $error("load reported a spike");
`endif
endmodule

>>> src/izk_ctrl.sv
// Controller for the Izhikevich neuron update unit: sequences one item
// through the shared multiplier datapath. Depends on izk_pkg.
module izk_ctrl import izk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_cmd,
    input  logic i_out_free,
    input  t_stat i_stat,
    output logic o_stall,
    output logic o_out_set,
    output t_cmd o_cmd
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_READ = 5'd1;
    localparam logic [4:0] S_FETCH = 5'd2;
    localparam logic [4:0] S_SPIKE = 5'd3;
    localparam logic [4:0] S_QV = 5'd4;
    localparam logic [4:0] S_QVV = 5'd5;
    localparam logic [4:0] S_LV = 5'd6;
    localparam logic [4:0] S_SUM = 5'd7;
    localparam logic [4:0] S_HS = 5'd8;
    localparam logic [4:0] S_DT = 5'd9;
    localparam logic [4:0] S_BV = 5'd10;
    localparam logic [4:0] S_AB = 5'd11;
    localparam logic [4:0] S_DTU = 5'd12;
    localparam logic [4:0] S_WRITE = 5'd13;
    localparam logic [4:0] S_DONE = 5'd14;
    localparam logic [4:0] S_ACC = 5'd15;

    logic [4:0] r_state, n_state;
    logic       r_pass, n_pass;
    logic       r_load, n_load;

    assign o_stall = (r_state != S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_pass = r_pass;
        n_load = r_load;
        o_cmd.op = OP_NONE;
        o_cmd.out_load = r_load;
        o_out_set = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_READ;
                    n_load = (i_cmd == CMD_LOAD);
                    n_pass = 1'b0;
                    o_cmd.op = (i_cmd == CMD_LOAD) ? OP_LOAD : OP_NONE;
                end
            end
            S_READ: begin
                o_cmd.op = OP_READ;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.op = OP_FETCH;
                n_state = (r_load || !i_stat.in_range) ? S_DONE : S_SPIKE;
            end
            S_SPIKE: begin
                o_cmd.op = OP_SPIKE;
                n_state = S_QV;
            end
            S_QV: begin o_cmd.op = OP_M_QV; n_state = S_QVV; end
            S_QVV: begin o_cmd.op = OP_M_QVV; n_state = S_LV; end
            S_LV: begin o_cmd.op = OP_M_LV; n_state = S_SUM; end
            S_SUM: begin o_cmd.op = OP_SUM; n_state = S_HS; end
            S_HS: begin o_cmd.op = OP_M_HS; n_state = S_DT; end
            S_DT: begin o_cmd.op = OP_M_DT; n_state = S_ACC; end
            // Add the half step to V, then run the second pass or the recovery update.
            S_ACC: begin
                o_cmd.op = OP_V_ACC;
                n_pass = 1'b1;
                n_state = r_pass ? S_BV : S_QV;
            end
            S_BV: begin o_cmd.op = OP_M_BV; n_state = S_AB; end
            S_AB: begin o_cmd.op = OP_M_AB; n_state = S_DTU; end
            S_DTU: begin o_cmd.op = OP_M_DTU; n_state = S_WRITE; end
            S_WRITE: begin o_cmd.op = OP_WRITE; n_state = S_DONE; end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_set = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass <= 1'b0;
            r_load <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass <= n_pass;
            r_load <= n_load;
        end
    end
endmodule

>>> src/izk_datapath.sv
// Datapath for the Izhikevich neuron update unit: neuron memories, one shared
// 32x32 multiplier with a product register, and the working registers. Uses izk_pkg.
module izk_datapath import izk_pkg::*; #(
    parameter int unsigned NEURON_COUNT = NEURON_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [IDX_W-1:0]   i_neuron,
    input  logic signed [31:0] i_syn,
    input  logic signed [31:0] i_pa,
    input  logic signed [31:0] i_pb,
    input  logic signed [31:0] i_pc,
    input  logic signed [31:0] i_pd,
    input  logic [30:0]        i_dt,
    input  logic signed [31:0] i_ioff,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic [IDX_W-1:0]   o_idx,
    output logic signed [31:0] o_v,
    output logic signed [31:0] o_u,
    output logic               o_spk
);
    localparam int unsigned AW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;

    logic signed [31:0] r_vmem [NEURON_COUNT];
    logic signed [31:0] r_umem [NEURON_COUNT];
    logic signed [31:0] r_amem [NEURON_COUNT];
    logic signed [31:0] r_bmem [NEURON_COUNT];
    logic signed [31:0] r_cmem [NEURON_COUNT];
    logic signed [31:0] r_dmem [NEURON_COUNT];
    logic [NEURON_COUNT-1:0] r_valid;

    logic [IDX_W-1:0]   r_idx;
    logic signed [31:0] r_syn, r_rv, r_ru, r_ra, r_rb, r_rc, r_rd;
    logic signed [31:0] r_v, r_u, r_vh, r_s, r_t;
    logic signed [63:0] r_prod;
    logic               r_spk, r_rvalid;
    logic signed [31:0] w_q, w_ma, w_mb;
    logic               w_range;
    logic [AW-1:0]      w_addr;

    assign w_addr = AW'(r_idx);
    assign w_range = (32'(r_idx) < NEURON_COUNT);
    assign w_q = qround(r_prod);
    assign o_stat.over = (r_v >= K_THRESH);
    assign o_stat.in_range = w_range;
    assign o_idx = r_idx;
    assign o_v = r_v;
    assign o_u = r_u;
    assign o_spk = r_spk;

    // Multiplier operand selection for the current operation.
    always_comb begin
        w_ma = r_vh;
        w_mb = r_vh;
        case (i_cmd.op)
            OP_M_QV: begin w_ma = K_QUAD; w_mb = r_vh; end
            OP_M_QVV: begin w_ma = w_q; w_mb = r_vh; end
            OP_M_LV: begin w_ma = K_LIN; w_mb = r_vh; end
            OP_M_HS: begin w_ma = K_HALF; w_mb = r_s; end
            OP_M_DT: begin w_ma = w_q; w_mb = $signed({1'b0, i_dt}); end
            OP_M_BV: begin w_ma = r_rb; w_mb = r_vh; end
            OP_M_AB: begin w_ma = r_ra; w_mb = qsub(w_q, r_u); end
            OP_M_DTU: begin w_ma = w_q; w_mb = $signed({1'b0, i_dt}); end
            default: begin w_ma = r_vh; w_mb = r_vh; end
        endcase
    end

    // Memory ports: one registered read, one write.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_READ && w_range) begin
            r_rv <= r_vmem[w_addr];
            r_ru <= r_umem[w_addr];
            r_ra <= r_amem[w_addr];
            r_rb <= r_bmem[w_addr];
            r_rc <= r_cmem[w_addr];
            r_rd <= r_dmem[w_addr];
            r_rvalid <= r_valid[w_addr];
        end
        if (i_cmd.op == OP_WRITE) begin
            r_vmem[w_addr] <= r_vh;
            r_umem[w_addr] <= qadd(r_u, w_q);
        end
        if (i_cmd.op == OP_LOAD && (32'(i_neuron) < NEURON_COUNT)) begin
            r_amem[AW'(i_neuron)] <= i_pa;
            r_bmem[AW'(i_neuron)] <= i_pb;
            r_cmem[AW'(i_neuron)] <= i_pc;
            r_dmem[AW'(i_neuron)] <= i_pd;
        end
    end

    // Valid bits for the state stores; an invalid entry reads as its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.op == OP_WRITE) begin
            r_valid[w_addr] <= 1'b1;
        end
    end

    // Working registers and the product register.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(w_ma) * 64'(w_mb);
        if (i_take) begin
            r_idx <= i_neuron;
            r_syn <= i_syn;
        end
        case (i_cmd.op)
            OP_FETCH: begin
                r_spk <= 1'b0;
                if (!w_range) begin
                    r_v <= '0;
                    r_u <= '0;
                end else begin
                    r_v <= r_rvalid ? r_rv : V_INIT;
                    r_u <= r_rvalid ? r_ru : U_INIT;
                end
            end
            OP_SPIKE: begin
                if (o_stat.over) begin
                    r_vh <= r_rc;
                    r_u <= qadd(r_u, r_rd);
                    r_spk <= 1'b1;
                end else begin
                    r_vh <= r_v;
                end
            end
            OP_M_LV: r_t <= w_q;
            OP_SUM: r_s <= qadd(qadd(qsub(qadd(qadd(r_t, w_q), K_CONST), r_u),
                                     r_syn), i_ioff);
            OP_M_BV: r_t <= r_vh;
            OP_V_ACC: r_vh <= qadd(r_vh, w_q);
            OP_WRITE: begin
                r_u <= qadd(r_u, w_q);
                r_v <= r_vh;
            end
            default: ;
        endcase
    end
endmodule

>>> test/tb_top.sv
// Self-checking testbench for the Izhikevich neuron update unit.
// Drives load/step items with random idling and checks every result against a Q16.16 predictor.
// Depends on izk_pkg and izhikevich_neuron_update_unit.
`timescale 1ns / 100ps

module tb_top import izk_pkg::*; ();

    typedef struct {
        logic              command;
        logic [7:0]        neuron;
        logic signed [31:0] syn;
        logic signed [31:0] pa;
        logic signed [31:0] pb;
        logic signed [31:0] pc;
        logic signed [31:0] pd;
    } t_cmd_item;

    typedef struct {
        logic [7:0]        neuron;
        logic signed [31:0] volt;
        logic signed [31:0] rec;
        logic              spk;
    } t_neuron_result;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, i_command;
    logic [7:0] i_neuron;
    logic signed [31:0] i_syn_current, i_param_a, i_param_b, i_param_c, i_param_d;
    logic i_cfg_we, i_cfg_addr;
    logic [31:0] i_cfg_data;
    logic o_valid, i_stall, o_spiked;
    logic [7:0] o_neuron_out;
    logic signed [31:0] o_voltage, o_recovery;

    izhikevich_neuron_update_unit uut (.*);

    // Predictor state.
    logic signed [31:0] m_volt [256];
    logic signed [31:0] m_rec [256];
    logic signed [31:0] m_a [256], m_b [256], m_c [256], m_d [256];
    bit                 m_loaded [256];
    logic signed [31:0] m_dt, m_ioff;

    t_cmd_item      pending_items[$];
    t_neuron_result expected_results[$];
    int  errors = 0;
    int  accepted_in = 0, accepted_out = 0, spikes_seen = 0;
    int  idle_cycles = 0;
    bit  quiet_in = 0, quiet_out = 0, hold_send = 0;
    bit  done = 0;
    localparam int WATCHDOG_LIMIT = 20000;

    // Q16.16 arithmetic written out with wide integers.
    function automatic logic signed [31:0] clamp64(longint x);
        if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] fx_add(logic signed [31:0] x, logic signed [31:0] y);
        return clamp64(longint'(x) + longint'(y));
    endfunction

    function automatic logic signed [31:0] fx_sub(logic signed [31:0] x, logic signed [31:0] y);
        return clamp64(longint'(x) - longint'(y));
    endfunction

    function automatic logic signed [31:0] fx_mul(logic signed [31:0] x, logic signed [31:0] y);
        longint p;
        p = longint'(x) * longint'(y) + 64'sd32768;
        return clamp64(p >>> 16);
    endfunction

    function automatic logic signed [31:0] euler_half(logic signed [31:0] v,
                                                      logic signed [31:0] u,
                                                      logic signed [31:0] isyn);
        logic signed [31:0] s;
        s = fx_mul(fx_mul(32'sd2621, v), v);
        s = fx_add(s, fx_mul(32'sd327680, v));
        s = fx_add(s, 32'sd9175040);
        s = fx_sub(s, u);
        s = fx_add(s, isyn);
        s = fx_add(s, m_ioff);
        return fx_add(v, fx_mul(fx_mul(32'sd32768, s), m_dt));
    endfunction

    // Advance the predictor by one item and queue the result it implies.
    task automatic predict_neuron(t_cmd_item it);
        t_neuron_result r;
        logic signed [31:0] v, u;
        int n;
        n = it.neuron;
        r.neuron = it.neuron;
        r.spk = 1'b0;
        v = m_volt[n];
        u = m_rec[n];
        if (it.command == CMD_LOAD) begin
            m_a[n] = it.pa; m_b[n] = it.pb; m_c[n] = it.pc; m_d[n] = it.pd;
        end else begin
            if (v >= 32'sd1966080) begin
                v = m_c[n];
                u = fx_add(u, m_d[n]);
                r.spk = 1'b1;
            end
            v = euler_half(v, u, it.syn);
            v = euler_half(v, u, it.syn);
            u = fx_add(u, fx_mul(fx_mul(m_a[n], fx_sub(fx_mul(m_b[n], v), u)), m_dt));
            m_volt[n] = v;
            m_rec[n] = u;
        end
        r.volt = v;
        r.rec = u;
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    endtask

    // Queue an item, replacing a step on a never-loaded neuron with a load.
    task automatic add_item(t_cmd_item it);
        if (it.command != CMD_LOAD && !m_loaded[it.neuron]) it.command = CMD_LOAD;
        if (it.command == CMD_LOAD) m_loaded[it.neuron] = 1;
        pending_items.push_back(it);
    endtask

    function automatic t_cmd_item mk(logic c, logic [7:0] n, logic signed [31:0] syn,
                                     logic signed [31:0] a, logic signed [31:0] b,
                                     logic signed [31:0] cc, logic signed [31:0] d);
        t_cmd_item it;
        it.command = c; it.neuron = n; it.syn = syn;
        it.pa = a; it.pb = b; it.pc = cc; it.pd = d;
        return it;
    endfunction

    function automatic logic signed [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 2000000)) - 32'sd1000000;
        endcase
    endfunction

    // Random item: mostly realistic regular-spiking style parameters.
    function automatic t_cmd_item rnd_item();
        t_cmd_item it;
        logic [7:0] n;
        n = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        if ($urandom_range(0, 9) < 7) begin
            it = mk(CMD_STEP, n, $signed($urandom_range(0, 1310720)) - 32'sd327680,
                    0, 0, 0, 0);
            if ($urandom_range(0, 19) == 0) it.syn = rnd_word();
        end else if ($urandom_range(0, 3) != 0) begin
            it = mk(CMD_LOAD, n, $urandom,
                    32'sd1311 + $signed($urandom_range(0, 5000)),
                    32'sd13107 + $signed($urandom_range(0, 5000)),
                    -32'sd4259840 + $signed($urandom_range(0, 655360)),
                    $signed($urandom_range(0, 524288)));
        end else begin
            it = mk(CMD_LOAD, n, rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word());
        end
        return it;
    endfunction

    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_addr <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_TIME_STEP) m_dt = $signed({1'b0, val[30:0]});
        else m_ioff = val;
    endtask

    task automatic drain_and_wait();
        while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Clock.
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Driver: presents queued items; an item leaves the queue when accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_neuron(pending_items.pop_front());
                accepted_in++;
            end
            if (!(i_valid && o_stall)) begin
                if (pending_items.size() != 0 && !hold_send &&
                    (quiet_in || $urandom_range(0, 99) >= 30)) begin
                    i_valid <= 1'b1;
                    i_command <= pending_items[0].command;
                    i_neuron <= pending_items[0].neuron;
                    i_syn_current <= pending_items[0].syn;
                    i_param_a <= pending_items[0].pa;
                    i_param_b <= pending_items[0].pb;
                    i_param_c <= pending_items[0].pc;
                    i_param_d <= pending_items[0].pd;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result and drives random stall.
    always @(posedge i_clk) begin
        t_neuron_result w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= !quiet_out && ($urandom_range(0, 99) < 30);
            if (o_valid && !i_stall) begin
                accepted_out++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, neuron", o_neuron_out, -1);
                end else begin
                    w = expected_results.pop_front();
                    if (o_neuron_out !== w.neuron) report_mismatch("neuron", o_neuron_out, w.neuron);
                    if (o_voltage !== w.volt) report_mismatch("voltage", o_voltage, w.volt);
                    if (o_recovery !== w.rec) report_mismatch("recovery", o_recovery, w.rec);
                    if (o_spiked !== w.spk) report_mismatch("spiked", o_spiked, w.spk);
                    if (w.spk) spikes_seen++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || done || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired");
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        i_rst_n = 0; i_valid = 0; i_stall = 0; i_command = 0; i_neuron = 0;
        i_syn_current = 0; i_param_a = 0; i_param_b = 0; i_param_c = 0; i_param_d = 0;
        i_cfg_we = 0; i_cfg_addr = 0; i_cfg_data = 0;
        for (int i = 0; i < 256; i++) begin
            m_volt[i] = V_INIT; m_rec[i] = U_INIT; m_loaded[i] = 0;
            m_a[i] = 0; m_b[i] = 0; m_c[i] = 0; m_d[i] = 0;
        end
        m_dt = 32'sd6554; m_ioff = 32'sd655360;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: loads at the field extremes, steps, spikes and saturation.
        add_item(mk(CMD_LOAD, 8'd0, 0, 32'sd1311, 32'sd13107, -32'sd4259840, 32'sd524288));
        add_item(mk(CMD_STEP, 8'd0, 0, 0, 0, 0, 0));
        add_item(mk(CMD_LOAD, 8'd255, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                    32'sh7FFF_FFFF, 32'sh8000_0000));
        add_item(mk(CMD_STEP, 8'd255, 32'sh7FFF_FFFF, 0, 0, 0, 0));
        add_item(mk(CMD_STEP, 8'd255, 32'sh8000_0000, 0, 0, 0, 0));
        add_item(mk(CMD_STEP, 8'd255, 32'sh7FFF_FFFF, 0, 0, 0, 0));
        add_item(mk(CMD_STEP, 8'd255, 32'sh7FFF_FFFF, 0, 0, 0, 0));
        add_item(mk(CMD_LOAD, 8'd1, -1, 32'sh8000_0000, 32'sh7FFF_FFFF,
                    32'sh8000_0000, 32'sh7FFF_FFFF));
        for (int k = 0; k < 8; k++) add_item(mk(CMD_STEP, 8'd1, 32'sd40000000, 0, 0, 0, 0));
        add_item(mk(CMD_LOAD, 8'd0, 0, 0, 0, 0, 0));
        for (int k = 0; k < 5; k++) add_item(mk(CMD_STEP, 8'd0, 32'sd20000000, 0, 0, 0, 0));

        // Register extremes, with the sender held off until everything is back.
        drain_and_wait();
        write_reg(REG_TIME_STEP, 32'h7FFF_FFFF);
        write_reg(REG_OFFSET, 32'h8000_0000);
        add_item(mk(CMD_STEP, 8'd0, 0, 0, 0, 0, 0));
        add_item(mk(CMD_STEP, 8'd255, 32'sh7FFF_FFFF, 0, 0, 0, 0));
        drain_and_wait();
        write_reg(REG_TIME_STEP, 32'h0);
        write_reg(REG_OFFSET, 32'h7FFF_FFFF);
        add_item(mk(CMD_STEP, 8'd1, 0, 0, 0, 0, 0));
        drain_and_wait();
        write_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
        write_reg(REG_OFFSET, 32'h0);
        add_item(mk(CMD_STEP, 8'd1, 0, 0, 0, 0, 0));
        drain_and_wait();

        // Random phases at several register settings.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin write_reg(REG_TIME_STEP, 32'd6554); write_reg(REG_OFFSET, 32'd655360); end
                1: begin write_reg(REG_TIME_STEP, 32'd32768); write_reg(REG_OFFSET, 32'd0); end
                2: begin write_reg(REG_TIME_STEP, $urandom_range(1, 100000));
                         write_reg(REG_OFFSET, $urandom); end
                default: begin write_reg(REG_TIME_STEP, 32'd6554);
                               write_reg(REG_OFFSET, 32'd1310720); end
            endcase
            quiet_in = (ph == 1); quiet_out = (ph == 1);
            for (int k = 0; k < 125; k++) add_item(rnd_item());
            if (ph == 2) begin
                while (pending_items.size() > 60) @(posedge i_clk);
                hold_send = 1;
                while (expected_results.size() != 0) @(posedge i_clk);
                hold_send = 0;
            end
            drain_and_wait();
        end

        done = 1;
        $display("Covered %0d items in, %0d results out, %0d spikes, four register settings.",
                 accepted_in, accepted_out, spikes_seen);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

>>> sim.f
src/izk_pkg.sv
src/izk_ctrl.sv
src/izk_datapath.sv
src/izhikevich_neuron_update_unit.sv
test/tb_top.sv
